// File: rtl/nbw_pkg.sv
// Shared constants and types of the NAL bitstream writer.
// Holds the command codes and the controller/datapath interface structs.
// Used by nbw_ctrl, nbw_datapath and nal_bitstream_writer; depends on nothing.
package nbw_pkg;

  localparam int VALUE_WIDTH = 32;

  // Operand mask and the largest value an Exp-Golomb code can carry.
  localparam logic [31:0] VAL_MASK = 32'((64'd1 << VALUE_WIDTH) - 64'd1);
  localparam logic [31:0] UE_LIMIT = VAL_MASK - 32'd1;

  localparam logic [2:0] CMD_FIXED = 3'd0;
  localparam logic [2:0] CMD_UE    = 3'd1;
  localparam logic [2:0] CMD_SE    = 3'd2;
  localparam logic [2:0] CMD_ALIGN = 3'd3;
  localparam logic [2:0] CMD_TRAIL = 3'd4;
  localparam logic [2:0] CMD_END   = 3'd5;

  localparam logic [7:0] ESC_BYTE = 8'h03;

  typedef struct packed {
    logic load;
    logic prep;
    logic norm_step;
    logic run_step;
    logic push_esc;
    logic push_byte;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic norm_top;
    logic rem_zero;
    logic byte_done;
    logic need_esc;
    logic out_free;
  } ctrl_sts_t;

endpackage

// File: rtl/nbw_ctrl.sv
// Controller of the NAL bitstream writer: sequences load, Exp-Golomb
// normalization, bit packing and byte output. Depends on nbw_pkg.
module nbw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [2:0]         cmd,
  output logic               in_ready,
  input  nbw_pkg::ctrl_sts_t sts,
  output nbw_pkg::ctrl_cmd_t ctl
);
  import nbw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_NORM,
    S_RUN,
    S_OUT
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          if (cmd == CMD_UE || cmd == CMD_SE) begin
            state_next = S_PREP;
          end else begin
            state_next = S_RUN;
          end
        end
      end
      S_PREP: begin
        ctl.prep   = 1'b1;
        state_next = S_NORM;
      end
      S_NORM: begin
        if (sts.norm_top) begin
          state_next = S_RUN;
        end else begin
          ctl.norm_step = 1'b1;
        end
      end
      S_RUN: begin
        if (sts.rem_zero) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.run_step = 1'b1;
          if (sts.byte_done) begin
            state_next = S_OUT;
          end
        end
      end
      S_OUT: begin
        // An escape byte clears the zero run, so the data byte follows next.
        if (sts.out_free) begin
          if (sts.need_esc) begin
            ctl.push_esc = 1'b1;
          end else begin
            ctl.push_byte = 1'b1;
            state_next    = S_RUN;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/nbw_datapath.sv
// Datapath of the NAL bitstream writer: pending bit string, partial byte,
// zero run, Exp-Golomb normalizer and output register. Depends on nbw_pkg.
module nbw_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         cmd,
  input  logic [5:0]         nbits,
  input  logic [31:0]        value,
  input  logic signed [31:0] signed_value,
  input  nbw_pkg::ctrl_cmd_t ctl,
  output nbw_pkg::ctrl_sts_t sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               is_escape,
  output logic               last
);
  import nbw_pkg::*;

  // Control state.
  logic [7:0]  partial;
  logic [2:0]  bcnt;
  logic [1:0]  zrun;

  // Payload.
  logic [63:0] pend;
  logic [6:0]  rem;
  logic [32:0] arg;
  logic [31:0] norm;
  logic        end_flag;
  logic [7:0]  done_byte;
  logic        done_last;

  // Load-time decode.
  logic [31:0] valw;
  logic [5:0]  nsat;
  logic [31:0] sv_u;
  logic [31:0] negmag;
  logic [32:0] mapped;
  logic [31:0] sat;
  logic [31:0] m;

  // Packing step.
  logic [3:0]  space;
  logic [3:0]  k;
  logic [7:0]  chunk;
  logic [7:0]  partial_next;
  logic [3:0]  sum;
  logic [6:0]  rem_next;

  assign valw   = value & VAL_MASK;
  assign nsat   = (nbits > 6'd32) ? 6'd32 : nbits;
  assign sv_u   = 32'(signed_value);
  assign negmag = ~sv_u + 32'd1;

  // Positive v maps to 2v-1, zero and negative v map to -2v.
  always_comb begin
    if (sv_u[31]) begin
      mapped = {negmag, 1'b0};
    end else if (sv_u == 32'd0) begin
      mapped = '0;
    end else begin
      mapped = {sv_u, 1'b0} - 33'd1;
    end
  end

  assign sat = (arg > {1'b0, UE_LIMIT}) ? UE_LIMIT : arg[31:0];
  assign m   = sat + 32'd1;

  assign space        = 4'd8 - {1'b0, bcnt};
  assign k            = (rem < {3'b0, space}) ? rem[3:0] : space;
  assign chunk        = pend[63:56] & ~(8'hFF >> k);
  assign partial_next = partial | (chunk >> bcnt);
  assign sum          = {1'b0, bcnt} + k;
  assign rem_next     = rem - {3'b0, k};

  assign sts.norm_top  = norm[31];
  assign sts.rem_zero  = (rem == 7'd0);
  assign sts.byte_done = (sum == 4'd8);
  assign sts.need_esc  = (zrun == 2'd2) && (done_byte[7:2] == 6'd0);
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      partial   <= '0;
      bcnt      <= '0;
      zrun      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.run_step) begin
        if (sum == 4'd8) begin
          partial <= '0;
          bcnt    <= '0;
        end else begin
          partial <= partial_next;
          bcnt    <= sum[2:0];
        end
      end
      if (ctl.push_esc) begin
        zrun <= '0;
      end else if (ctl.push_byte) begin
        if (done_byte != 8'd0) begin
          zrun <= '0;
        end else if (zrun != 2'd2) begin
          zrun <= zrun + 2'd1;
        end
      end else if (ctl.finish && end_flag) begin
        zrun <= '0;
      end
      if (ctl.push_esc || ctl.push_byte) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      end_flag <= (cmd == CMD_END);
      arg      <= (cmd == CMD_SE) ? mapped : {1'b0, valw};
      case (cmd)
        CMD_FIXED: begin
          pend <= {valw << (6'd32 - nsat), 32'd0};
          rem  <= {1'b0, nsat};
        end
        CMD_ALIGN, CMD_END: begin
          pend <= '0;
          rem  <= {4'd0, 3'd0 - bcnt};
        end
        CMD_TRAIL: begin
          pend <= {1'b1, 63'd0};
          rem  <= {3'd0, space};
        end
        default: begin
          pend <= '0;
          rem  <= '0;
        end
      endcase
    end else if (ctl.prep) begin
      // The code is (len-1) zeros and then m; each normalize shift of m by s
      // drops 2s leading positions of the 63-bit field.
      norm <= m;
      pend <= {31'd0, m, 1'b0};
      rem  <= 7'd63;
    end else if (ctl.norm_step) begin
      if (norm[31:24] == 8'd0) begin
        norm <= norm << 8;
        pend <= pend << 16;
        rem  <= rem - 7'd16;
      end else begin
        norm <= norm << 1;
        pend <= pend << 2;
        rem  <= rem - 7'd2;
      end
    end else if (ctl.run_step) begin
      pend <= pend << k;
      rem  <= rem_next;
      if (sum == 4'd8) begin
        done_byte <= partial_next;
        done_last <= (rem_next < 7'd8);
      end
    end
    if (ctl.push_esc) begin
      out_byte  <= ESC_BYTE;
      is_escape <= 1'b1;
      last      <= 1'b0;
    end else if (ctl.push_byte) begin
      out_byte  <= done_byte;
      is_escape <= 1'b0;
      last      <= done_last;
    end
  end

endmodule

// File: rtl/nal_bitstream_writer.sv
// NAL bitstream writer: one command in, escaped NAL bytes out, MSB first.
// The controller loads a command, prepares and normalizes Exp-Golomb codes, then packs
// bits and hands each full byte, after an escape byte where one is needed, to the output
// register, which out_ready can stall. One item at a time: a new command is accepted
// only in idle, once the previous one has been packed.
// Reset (rst, synchronous) clears partial byte, bit count, zero run, output valid.
module nal_bitstream_writer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         cmd,
  input  logic [5:0]         nbits,
  input  logic [31:0]        value,
  input  logic signed [31:0] signed_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               is_escape,
  output logic               last
);
  import nbw_pkg::*;

  ctrl_cmd_t ctl;
  ctrl_sts_t sts;

  nbw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  nbw_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .nbits        (nbits),
    .value        (value),
    .signed_value (signed_value),
    .ctl          (ctl),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .is_escape    (is_escape),
    .last         (last)
  );

endmodule
